// ===== rtl/frtlb_pkg.sv =====
// ----------------------------------------------------------------------------
// frtlb_pkg
// Shared codes and controller/datapath signal groups of the FIFO-replacement
// translation buffer.
// ----------------------------------------------------------------------------
package frtlb_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned OUT_FRAME_W = 8;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the accepted transaction, rewind the scan
    logic step;      // issue the next slot read of the walk
    logic finish;    // commit the state update and capture the result
    logic out_load;  // move the captured result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic imm;        // completes without a walk
    logic found;      // the slot under compare is the one wanted
    logic exhausted;  // the last slot of the walk is under compare
    logic out_free;   // output register can take a result this cycle
  } ctrl_sts_t;

endpackage

// ===== rtl/frtlb_if.sv =====
// ----------------------------------------------------------------------------
// frtlb_req_if / frtlb_rsp_if
// Valid/ready channels carrying requests into and results out of the buffer.
// ----------------------------------------------------------------------------
interface frtlb_req_if #(
  parameter int unsigned PAGE_BITS  = 8,
  parameter int unsigned FRAME_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic [PAGE_BITS-1:0]  page;
  logic [FRAME_BITS-1:0] frame;

  modport source (output valid, output cmd, output page, output frame, input ready);
  modport sink   (input valid, input cmd, input page, input frame, output ready);
endinterface

interface frtlb_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [7:0] frame_out;

  modport source (output valid, output hit, output frame_out, input ready);
  modport sink   (input valid, input hit, input frame_out, output ready);
endinterface

// ===== rtl/frtlb_ctrl.sv =====
// ----------------------------------------------------------------------------
// frtlb_ctrl
// Sequencer: accepts a transaction, walks the ring one slot per cycle until
// the datapath reports a decision, then hands the result to the output.
// ----------------------------------------------------------------------------
module frtlb_ctrl
  import frtlb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.imm || sts_i.found || sts_i.exhausted) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/frtlb_dp.sv =====
// ----------------------------------------------------------------------------
// frtlb_dp
// Datapath: tag and frame memories, valid bits, ring head and fill count,
// the one-slot-per-cycle compare stage and the output register.
// ----------------------------------------------------------------------------
module frtlb_dp
  import frtlb_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 8,
  parameter int unsigned FRAME_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CMD_W-1:0]       in_cmd_i,
  input  logic [PAGE_BITS-1:0]   in_page_i,
  input  logic [FRAME_BITS-1:0]  in_frame_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic                   out_hit_o,
  output logic [OUT_FRAME_W-1:0] out_frame_o,
  input  ctrl_cmd_t              cmd_i,
  output ctrl_sts_t              sts_o
);

  localparam int unsigned IDX_W = $clog2(TLB_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TLB_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TLB_ENTRIES);

  logic [PAGE_BITS-1:0]  tag_mem [TLB_ENTRIES];
  logic [FRAME_BITS-1:0] frm_mem [TLB_ENTRIES];

  logic [TLB_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]       head_q;
  logic [CNT_W-1:0]       count_q;
  logic [IDX_W-1:0]       rd_ptr_q;
  logic [CNT_W-1:0]       iss_cnt_q;
  logic                   s1_vld_q;
  logic [IDX_W-1:0]       s1_slot_q;
  logic                   s1_last_q;
  logic                   out_valid_q;

  logic [CMD_W-1:0]       cmd_q;
  logic [PAGE_BITS-1:0]   page_q;
  logic [FRAME_BITS-1:0]  frame_q;
  logic [PAGE_BITS-1:0]   rd_tag_q;
  logic [FRAME_BITS-1:0]  rd_frm_q;
  logic                   res_hit_q;
  logic [OUT_FRAME_W-1:0] res_frm_q;
  logic                   out_hit_q;
  logic [OUT_FRAME_W-1:0] out_frm_q;

  logic             full;
  logic             imm;
  logic             found;
  logic             issue;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    ring_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign full  = (count_q == FULL_CNT);
  assign imm   = (cmd_q == CMD_UNUSED) || ((cmd_q == CMD_INSERT) && full);
  assign found = s1_vld_q && ((cmd_q == CMD_INSERT) ? !valid_q[s1_slot_q]
                              : (valid_q[s1_slot_q] && (rd_tag_q == page_q)));
  assign issue = cmd_i.step && (iss_cnt_q != FULL_CNT);

  // insert into a full ring replaces the head, otherwise the free slot found
  assign wr_en   = cmd_i.finish && (cmd_q == CMD_INSERT) && (imm || found);
  assign wr_addr = imm ? head_q : s1_slot_q;

  assign sts_o.imm       = imm;
  assign sts_o.found     = found;
  assign sts_o.exhausted = s1_vld_q && s1_last_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_frame_o = out_frm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      head_q      <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      iss_cnt_q   <= '0;
      s1_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_ptr_q  <= head_q;
        iss_cnt_q <= '0;
        s1_vld_q  <= 1'b0;
      end else begin
        s1_vld_q <= issue;
        if (issue) begin
          rd_ptr_q  <= ring_inc(rd_ptr_q);
          iss_cnt_q <= iss_cnt_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (wr_en) begin
          valid_q[wr_addr] <= 1'b1;
        end
        if ((cmd_q == CMD_INSERT) && imm) begin
          head_q <= ring_inc(head_q);
        end else if ((cmd_q == CMD_INSERT) && found) begin
          count_q <= count_q + 1'b1;
        end else if ((cmd_q == CMD_INVAL) && found) begin
          valid_q[s1_slot_q] <= 1'b0;
          count_q            <= count_q - 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_cmd_i;
      page_q  <= in_page_i;
      frame_q <= in_frame_i;
    end
    if (issue) begin
      s1_slot_q <= rd_ptr_q;
      s1_last_q <= (iss_cnt_q == CNT_W'(TLB_ENTRIES - 1));
    end
    if (cmd_i.finish) begin
      res_hit_q <= !imm && found && (cmd_q != CMD_INSERT);
      res_frm_q <= (!imm && found && (cmd_q == CMD_LOOKUP)) ? OUT_FRAME_W'(rd_frm_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_hit_q <= res_hit_q;
      out_frm_q <= res_frm_q;
    end
  end

  // tag/frame memories with one write port and one read port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= page_q;
      frm_mem[wr_addr] <= frame_q;
    end
    if (issue) begin
      rd_tag_q <= tag_mem[rd_ptr_q];
      rd_frm_q <= frm_mem[rd_ptr_q];
    end
  end

endmodule

// ===== rtl/fifo_replacement_tlb_top.sv =====
// ----------------------------------------------------------------------------
// fifo_replacement_tlb_top
// Fully associative translation buffer with FIFO replacement.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. A lookup, an invalidate or an insert
// into a buffer that is not full walks the ring from the head slot, one slot
// per cycle through the single read port of the tag and frame memories, and
// stops at the first slot that decides it, or after all TLB_ENTRIES slots
// (a miss); an insert into a full buffer and the unused command complete
// without a walk. Results sit in an output register, and the next
// transaction is taken while a result waits there; a second finished
// result holds the input off until the first one leaves.
module fifo_replacement_tlb_top
  import frtlb_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 8,
  parameter int unsigned FRAME_BITS  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  frtlb_req_if.sink    req_i,
  frtlb_rsp_if.source  rsp_o
);

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  frtlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  frtlb_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_BITS   (PAGE_BITS),
    .FRAME_BITS  (FRAME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_cmd_i    (req_i.cmd),
    .in_page_i   (req_i.page),
    .in_frame_i  (req_i.frame),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .out_hit_o   (rsp_o.hit),
    .out_frame_o (rsp_o.frame_out),
    .cmd_i       (ctrl_cmd),
    .sts_o       (ctrl_sts)
  );

endmodule

// ===== rtl/frtlb_chk.sv =====
// ----------------------------------------------------------------------------
// frtlb_chk
// Port-level checks of the translation buffer, bound to the top level.
// ----------------------------------------------------------------------------
module frtlb_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_hit_i,
  input logic [7:0] rsp_frame_out_i
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_hit_i) && $stable(rsp_frame_out_i))
    else $error("result changed while stalled");

  // a frame is only reported on a hit
  a_frame_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_hit_i |-> rsp_frame_out_i == 8'd0)
    else $error("frame reported without hit");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

endmodule

bind fifo_replacement_tlb_top frtlb_chk u_frtlb_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_hit_i       (rsp_o.hit),
  .rsp_frame_out_i (rsp_o.frame_out)
);

// ===== test/fifo_replacement_tlb_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_replacement_tlb_top_tb
// Drives lookup, insert, invalidate and unused transactions into the FIFO
// replacement translation buffer with random gaps and stalls on both
// channels. A behavioral copy of the buffer predicts each result, and a
// monitor compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module fifo_replacement_tlb_top_tb;
  import frtlb_pkg::*;

  localparam int unsigned TLB_ENTRIES = 16;
  localparam int unsigned PAGE_BITS   = 8;
  localparam int unsigned FRAME_BITS  = 8;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } tlb_req_t;

  typedef struct packed {
    logic                   hit;
    logic [OUT_FRAME_W-1:0] frame_out;
  } tlb_rsp_t;

  logic clk;
  logic rst_n;

  frtlb_req_if #(.PAGE_BITS(PAGE_BITS), .FRAME_BITS(FRAME_BITS)) req_if ();
  frtlb_rsp_if rsp_if ();

  fifo_replacement_tlb_top #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the buffer
  logic [PAGE_BITS-1:0]  shadow_tag   [TLB_ENTRIES];
  logic [FRAME_BITS-1:0] shadow_frame [TLB_ENTRIES];
  logic                  shadow_valid [TLB_ENTRIES];
  logic [3:0]            shadow_head;
  logic [4:0]            shadow_count;

  tlb_req_t pending_req_q[$];
  tlb_rsp_t translation_q[$];

  int unsigned error_cnt;
  int unsigned accepted_cnt;
  int unsigned total_items;
  logic        hold_off;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_cnt++;
  endtask

  // first valid slot holding the page, searched from the head; -1 if none
  function automatic int find_slot(input logic [PAGE_BITS-1:0] page);
    int unsigned s;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      s = (shadow_head + k) % TLB_ENTRIES;
      if (shadow_valid[s] && shadow_tag[s] == page) return s;
    end
    return -1;
  endfunction

  task automatic translate_and_update(input tlb_req_t rq);
    tlb_rsp_t rs;
    int       s;
    int unsigned p;
    rs = '0;
    case (rq.cmd)
      CMD_LOOKUP: begin
        s = find_slot(rq.page);
        if (s >= 0) begin
          rs.hit       = 1'b1;
          rs.frame_out = shadow_frame[s];
        end
      end
      CMD_INSERT: begin
        if (shadow_count < TLB_ENTRIES) begin
          for (int k = 0; k < TLB_ENTRIES; k++) begin
            p = (shadow_head + k) % TLB_ENTRIES;
            if (!shadow_valid[p]) begin
              shadow_tag[p]   = rq.page;
              shadow_frame[p] = rq.frame;
              shadow_valid[p] = 1'b1;
              shadow_count    = shadow_count + 1'b1;
              break;
            end
          end
        end else begin
          // full: overwrite the head slot and move the head on
          shadow_tag[shadow_head]   = rq.page;
          shadow_frame[shadow_head] = rq.frame;
          shadow_valid[shadow_head] = 1'b1;
          shadow_head               = shadow_head + 1'b1;
        end
      end
      CMD_INVAL: begin
        s = find_slot(rq.page);
        if (s >= 0) begin
          shadow_valid[s] = 1'b0;
          if (shadow_count > 0) shadow_count = shadow_count - 1'b1;
          rs.hit = 1'b1;
        end
      end
      default: ;
    endcase
    translation_q.push_back(rs);
  endtask

  function automatic tlb_req_t make_req(input logic [CMD_W-1:0] cmd,
                                        input logic [PAGE_BITS-1:0] page,
                                        input logic [FRAME_BITS-1:0] frame);
    tlb_req_t rq;
    rq.cmd   = cmd;
    rq.page  = page;
    rq.frame = frame;
    return rq;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  int unsigned drv_gap_left;
  int unsigned drv_burst_left;

  always @(posedge clk or negedge rst_n) begin
    tlb_req_t rq;
    if (!rst_n) begin
      req_if.valid   <= 1'b0;
      req_if.cmd     <= CMD_LOOKUP;
      req_if.page    <= '0;
      req_if.frame   <= '0;
      accepted_cnt   <= 0;
      drv_gap_left   = 0;
      drv_burst_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        translate_and_update(make_req(req_if.cmd, req_if.page, req_if.frame));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (drv_gap_left != 0) begin
          req_if.valid <= 1'b0;
          drv_gap_left = drv_gap_left - 1;
        end else if (pending_req_q.size() != 0) begin
          rq = pending_req_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.cmd   <= rq.cmd;
          req_if.page  <= rq.page;
          req_if.frame <= rq.frame;
          if (drv_burst_left != 0) begin
            drv_burst_left = drv_burst_left - 1;
            drv_gap_left   = 0;
          end else if ($urandom_range(0, 19) == 0) begin
            drv_burst_left = 25;
            drv_gap_left   = 0;
          end else begin
            drv_gap_left = $urandom_range(0, 6);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned mon_stall_left;
  int unsigned mon_burst_left;

  always @(posedge clk or negedge rst_n) begin
    tlb_rsp_t want;
    int unsigned stall;
    if (!rst_n) begin
      rsp_if.ready   <= 1'b0;
      mon_stall_left = 0;
      mon_burst_left = 0;
    end else begin
      stall = mon_stall_left;
      if (rsp_if.valid && rsp_if.ready) begin
        if (translation_q.size() == 0) begin
          report_mismatch("response with no pending transaction", rsp_if.hit, 0);
        end else begin
          want = translation_q.pop_front();
          if (rsp_if.hit !== want.hit)
            report_mismatch("hit", rsp_if.hit, want.hit);
          if (rsp_if.frame_out !== want.frame_out)
            report_mismatch("frame_out", rsp_if.frame_out, want.frame_out);
        end
        if (mon_burst_left != 0) begin
          mon_burst_left = mon_burst_left - 1;
          stall = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          mon_burst_left = 25;
          stall = 0;
        end else begin
          stall = $urandom_range(0, 6);
        end
      end
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
      end else if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        stall = stall - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
      mon_stall_left = stall;
    end
  end

  // long receiver hold-off so the buffer backs up into the request channel
  initial begin
    hold_off = 1'b0;
    while (accepted_cnt < 120) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2ms;
    $display("fifo_replacement_tlb_top_tb: FAIL");
    $finish;
  end

  initial begin
    logic [PAGE_BITS-1:0] page_pool[24];
    int unsigned w_ins, w_look, w_inv, sel;
    logic [CMD_W-1:0]      cmd;
    logic [PAGE_BITS-1:0]  page;

    rst_n        = 1'b0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i]   = '0;
      shadow_frame[i] = '0;
    end
    shadow_head  = '0;
    shadow_count = '0;

    // empty buffer misses, unused command, extremes, duplicates
    pending_req_q.push_back(make_req(CMD_LOOKUP, 8'h00, 8'hff));
    pending_req_q.push_back(make_req(CMD_INVAL,  8'hff, 8'hff));
    pending_req_q.push_back(make_req(CMD_UNUSED, 8'hff, 8'hff));
    pending_req_q.push_back(make_req(CMD_INSERT, 8'h00, 8'hff));
    pending_req_q.push_back(make_req(CMD_INSERT, 8'hff, 8'h00));
    pending_req_q.push_back(make_req(CMD_INSERT, 8'h00, 8'h5a));
    pending_req_q.push_back(make_req(CMD_LOOKUP, 8'h00, 8'h00));
    pending_req_q.push_back(make_req(CMD_LOOKUP, 8'hff, 8'hff));
    pending_req_q.push_back(make_req(CMD_INVAL,  8'h00, 8'ha5));
    pending_req_q.push_back(make_req(CMD_LOOKUP, 8'h00, 8'h00));
    pending_req_q.push_back(make_req(CMD_UNUSED, 8'h00, 8'h00));
    pending_req_q.push_back(make_req(CMD_LOOKUP, 8'h00, 8'h00));
    pending_req_q.push_back(make_req(CMD_INVAL,  8'h77, 8'h00));
    pending_req_q.push_back(make_req(CMD_INVAL,  8'h00, 8'h00));
    pending_req_q.push_back(make_req(CMD_LOOKUP, 8'h00, 8'h00));

    // random phases rotate between filling, draining and mixed command weightings
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        for (int i = 0; i < 24; i++) page_pool[i] = PAGE_BITS'($urandom_range(0, 255));
        case ((n / 100) % 3)
          0:       begin w_ins = 50; w_look = 30; w_inv = 15; end
          1:       begin w_ins = 20; w_look = 35; w_inv = 40; end
          default: begin w_ins = 35; w_look = 40; w_inv = 20; end
        endcase
      end
      sel = $urandom_range(0, 99);
      if (sel < w_ins)                       cmd = CMD_INSERT;
      else if (sel < w_ins + w_look)         cmd = CMD_LOOKUP;
      else if (sel < w_ins + w_look + w_inv) cmd = CMD_INVAL;
      else                                   cmd = CMD_UNUSED;
      if ($urandom_range(0, 9) < 8) page = page_pool[$urandom_range(0, 23)];
      else page = PAGE_BITS'($urandom_range(0, 255));
      pending_req_q.push_back(make_req(cmd, page, FRAME_BITS'($urandom_range(0, 255))));
    end
    total_items = pending_req_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted_cnt < total_items) @(posedge clk);
    while (translation_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (translation_q.size() != 0)
      report_mismatch("transactions left without response", translation_q.size(), 0);

    if (error_cnt == 0) begin
      $display("fifo_replacement_tlb_top_tb: PASS");
    end else begin
      $display("fifo_replacement_tlb_top_tb: FAIL");
    end
    $finish;
  end

endmodule
